### hw/rtl/bal_pkg.sv
// ============================================================================
// bal_pkg
// Shared constants of the cubic Bezier arc-length walker.
// ============================================================================
`default_nettype none

package bal_pkg;

  localparam int DEF_MAX_SUBDIVISIONS = 256;
  localparam int DEF_COORD_BITS       = 16;
  localparam int DEF_FRAC_BITS        = 8;

  localparam int OP_W     = 2;
  localparam int T_W      = 17;
  localparam int DIST_W   = 27;
  localparam int LEN_W    = 27;
  localparam int SUBDIV_W = 9;
  localparam int CFG_IDX_W = 3;

  localparam int SQ_W   = 64;
  localparam int ROOT_W = 33;

  localparam logic [OP_W-1:0] OP_EVAL    = 2'd0;
  localparam logic [OP_W-1:0] OP_LENGTH  = 2'd1;
  localparam logic [OP_W-1:0] OP_AT_DIST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_POINT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_GUIDE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_GUIDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_POINT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBDIVISIONS = 3'd4;

  localparam logic [SUBDIV_W-1:0] SUBDIV_RESET = 9'd64;
  localparam logic [T_W-1:0]      T_ONE        = 17'h10000;
  localparam logic [LEN_W-1:0]    LEN_MAX      = {LEN_W{1'b1}};

endpackage

`default_nettype wire

### hw/rtl/bal_if.sv
// ============================================================================
// bal_if
// Valid/ready channel interfaces for requests, results and configuration.
// ============================================================================
`default_nettype none

interface bal_in_if;
  import bal_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [T_W-1:0]    param_t;
  logic [DIST_W-1:0] distance;
  modport source (output valid, operation, param_t, distance, input ready);
  modport sink   (input valid, operation, param_t, distance, output ready);
endinterface

interface bal_out_if #(parameter int POS_W = 24);
  import bal_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [LEN_W-1:0]        curve_length;
  logic                    reached_end;
  modport source (output valid, pos_x, pos_y, pos_z, curve_length, reached_end,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, curve_length, reached_end,
                  output ready);
endinterface

interface bal_cfg_if #(parameter int DATA_W = 48);
  import bal_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/bal_div.sv
// ============================================================================
// bal_div
// Restoring divider, one quotient bit per cycle, for quotients below 2^Q_W.
// ============================================================================
`default_nettype none

module bal_div #(
  parameter int NUM_W = 50,
  parameter int DEN_W = 33,
  parameter int Q_W   = 17
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [Q_W-1:0]        quo
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0]   low_r;
  logic [Q_W-1:0]   quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem2;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign rem2 = {rem_r, low_r[Q_W-1]};
  assign diff = rem2 - {1'b0, den_r};
  assign ge   = rem2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        rem_r  <= DEN_W'(num >> Q_W);
        low_r  <= num[Q_W-1:0];
        den_r  <= den;
        cnt_r  <= '0;
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end else if (busy_r) begin
        rem_r <= ge ? DEN_W'(diff) : DEN_W'(rem2);
        low_r <= low_r << 1;
        quo_r <= {quo_r[Q_W-2:0], ge};
        if (cnt_r == CNT_W'(Q_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          done_r <= 1'b0;
        end
        cnt_r <= cnt_r + 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

### hw/rtl/bal_isqrt.sv
// ============================================================================
// bal_isqrt
// Bit-pair integer square root with round-to-nearest, one bit per cycle.
// ============================================================================
`default_nettype none

module bal_isqrt #(
  parameter int IN_W  = 64,
  parameter int OUT_W = 33
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [IN_W-1:0] din,
  output logic                 done,
  output logic [OUT_W-1:0]     root
);

  localparam int STEPS = IN_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [IN_W-1:0]  rem_r;
  logic [IN_W-1:0]  root_r;
  logic [IN_W-1:0]  bit_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [OUT_W-1:0] out_r;
  logic [IN_W:0]    trial;
  logic             take;

  assign trial = {1'b0, root_r} + {1'b0, bit_r};
  assign take  = {1'b0, rem_r} >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        rem_r  <= din;
        root_r <= '0;
        bit_r  <= IN_W'(1) << (IN_W - 2);
        cnt_r  <= '0;
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end else if (busy_r) begin
        if (take) begin
          rem_r  <= IN_W'({1'b0, rem_r} - trial);
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
        end
        cnt_r  <= cnt_r + 1'b1;
        done_r <= 1'b0;
      end else if (cnt_r == CNT_W'(STEPS)) begin
        out_r  <= OUT_W'(root_r) + OUT_W'(rem_r > root_r);
        done_r <= 1'b1;
        cnt_r  <= '0;
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign root = out_r;

endmodule

`default_nettype wire

### hw/rtl/bezier_arc_length_walker_core.sv
// ============================================================================
// bezier_arc_length_walker_core
// Cubic Bezier evaluation, chord-length sum and distance walk on one
// shared multiplier with an iterative divider and square root.
// ============================================================================
// The single multiplier runs the eighteen de Casteljau interpolations of
// each point one after another. Every chord of a length or distance
// request waits on the step divider and then on the square root, and a
// distance request that hits a chord ends with a final interpolation
// between its end points. A new request is taken while the previous
// result beat still waits.
`default_nettype none

module bezier_arc_length_walker_core
  import bal_pkg::*;
#(
  parameter int MAX_SUBDIVISIONS = DEF_MAX_SUBDIVISIONS,
  parameter int COORD_BITS       = DEF_COORD_BITS,
  parameter int FRAC_BITS        = DEF_FRAC_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bal_in_if.sink    in_bus,
  bal_out_if.source out_bus,
  bal_cfg_if.sink   cfg_bus
);

  localparam int PW     = COORD_BITS + FRAC_BITS;
  localparam int DW     = PW + 1;
  localparam int MAG_W  = PW;
  localparam int SH_MAX = (MAG_W > 31) ? MAG_W - 31 : 0;
  localparam int SH_W   = (SH_MAX > 0) ? $clog2(SH_MAX + 1) : 1;
  localparam int MA     = (DW > 32) ? DW : 32;
  localparam int SEG_W  = ROOT_W + SH_MAX;
  localparam int NW     = $clog2(MAX_SUBDIVISIONS + 1);
  localparam int CMPW   = (NW > SUBDIV_W) ? NW : SUBDIV_W;
  localparam int ACC_W  = SEG_W + NW;
  localparam int NUM_W  = SEG_W + T_W;
  localparam logic signed [2*MA-1:0] HALF = 32768;

  typedef enum logic [3:0] {
    S_IDLE, S_DIVGO, S_DIV, S_QSTEP, S_EVDONE, S_SQ, S_SQRT, S_CMP, S_OUT
  } state_t;

  typedef logic signed [PW-1:0] pos_t;

  state_t            state_r;
  logic [OP_W-1:0]   op_r;
  logic [T_W-1:0]    t_r;
  logic [DIST_W-1:0] dist_r;
  logic [NW-1:0]     n_r;
  logic [NW-1:0]     i_r;
  pos_t              q_r [12];
  logic              phase_r;
  logic [3:0]        sc_r;
  logic [1:0]        lvl_r;
  logic              interp_r;
  pos_t              first_r [3];
  pos_t              second_r [3];
  logic [ACC_W-1:0]  acc_r;
  logic [SQ_W-1:0]   sum_r;
  logic [1:0]        sq_cnt_r;
  logic signed [2*MA-1:0] prod_r;
  logic [SEG_W-1:0]  seg_r;
  pos_t              res_pos_r [3];
  logic [LEN_W-1:0]  res_len_r;
  logic              res_end_r;
  logic              out_valid_r;
  pos_t              out_pos_r [3];
  logic [LEN_W-1:0]  out_len_r;
  logic              out_end_r;
  logic [3*COORD_BITS-1:0] cp_r [4];
  logic [SUBDIV_W-1:0]     subdiv_r;

  pos_t                   cps [4][3];
  logic [NW-1:0]          n_cur;
  logic [SUBDIV_W-1:0]    sub_lo;
  logic [3:0]             nl;
  logic                   lerp_now;
  logic signed [DW-1:0]   lerp_diff;
  logic signed [2*MA-1:0] lerp_rnd;
  pos_t                   lerp_res;
  logic signed [MA-1:0]   mul_a;
  logic signed [MA-1:0]   mul_b;
  logic signed [2*MA-1:0] mul_p;
  logic [MAG_W-1:0]       mag [3];
  logic [MAG_W-1:0]       mag_max;
  logic [SH_W-1:0]        sh;
  logic [30:0]            sq_v [3];
  logic [30:0]            sq_sel;
  logic [ACC_W-1:0]       dist_ext;
  logic [ACC_W-1:0]       acc_seg;
  logic                   hit;
  logic [SEG_W-1:0]       offset;
  logic [NUM_W-1:0]       div_num;
  logic [SEG_W-1:0]       div_den;
  logic                   div_done;
  logic [T_W-1:0]         div_quo;
  logic                   sqrt_start;
  logic [SQ_W-1:0]        sqrt_din;
  logic                   sqrt_done;
  logic [ROOT_W-1:0]      sqrt_root;

  // Control points scaled to the position format.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++) begin
        cps[k][c] = pos_t'($signed(cp_r[k][c*COORD_BITS +: COORD_BITS])) <<< FRAC_BITS;
      end
    end
  end

  always_comb begin
    sub_lo = (subdiv_r == '0) ? SUBDIV_W'(1) : subdiv_r;
    if (CMPW'(sub_lo) > CMPW'(MAX_SUBDIVISIONS)) begin
      n_cur = NW'(MAX_SUBDIVISIONS);
    end else begin
      n_cur = NW'(sub_lo);
    end
  end

  assign nl        = interp_r ? 4'd3 : ({2'b00, lvl_r} << 1) + {2'b00, lvl_r};
  assign lerp_now  = sc_r < nl;
  assign lerp_diff = DW'(q_r[3]) - DW'(q_r[0]);
  assign lerp_rnd  = (prod_r + HALF) >>> 16;
  assign lerp_res  = q_r[0] + PW'(lerp_rnd);

  always_comb begin
    mag_max = '0;
    for (int c = 0; c < 3; c++) begin
      logic signed [DW-1:0] d;
      d = DW'(second_r[c]) - DW'(first_r[c]);
      mag[c] = d[DW-1] ? MAG_W'(-d) : MAG_W'(d);
      if (mag[c] > mag_max) begin
        mag_max = mag[c];
      end
    end
    sh = '0;
    for (int s = 0; s < SH_MAX; s++) begin
      if ((mag_max >> (31 + s)) != '0) begin
        sh = SH_W'(s + 1);
      end
    end
    for (int c = 0; c < 3; c++) begin
      sq_v[c] = 31'(mag[c] >> sh);
    end
  end

  always_comb begin
    case (sq_cnt_r)
      2'd0:    sq_sel = sq_v[0];
      2'd1:    sq_sel = sq_v[1];
      default: sq_sel = sq_v[2];
    endcase
  end

  always_comb begin
    if (state_r == S_SQ) begin
      mul_a = MA'($signed({1'b0, sq_sel}));
      mul_b = MA'($signed({1'b0, sq_sel}));
    end else begin
      mul_a = MA'(lerp_diff);
      mul_b = MA'($signed({1'b0, t_r}));
    end
  end

  assign mul_p = mul_a * mul_b;

  assign dist_ext = ACC_W'(dist_r);
  assign acc_seg  = acc_r + ACC_W'(seg_r);
  assign hit      = (op_r == OP_AT_DIST) && (acc_seg > dist_ext);
  assign offset   = SEG_W'(dist_ext - acc_r);
  assign div_num  = interp_r ?
                    (NUM_W'(offset) << 16) + NUM_W'(seg_r >> 1) :
                    NUM_W'({i_r, 16'h0000}) + NUM_W'(n_r >> 1);
  assign div_den  = interp_r ? seg_r : SEG_W'(n_r);

  assign sqrt_start = (state_r == S_SQ) && (sq_cnt_r == 2'd3);
  assign sqrt_din   = sum_r + prod_r[SQ_W-1:0];

  bal_div #(
    .NUM_W (NUM_W),
    .DEN_W (SEG_W),
    .Q_W   (T_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DIVGO),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  bal_isqrt #(
    .IN_W  (SQ_W),
    .OUT_W (ROOT_W)
  ) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .din   (sqrt_din),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign in_bus.ready  = (state_r == S_IDLE);
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        cp_r[k] <= '0;
      end
      subdiv_r <= SUBDIV_RESET;
    end else begin
      if (cfg_bus.valid) begin
        case (cfg_bus.index)
          CFG_START_POINT:  cp_r[0]  <= cfg_bus.data;
          CFG_FIRST_GUIDE:  cp_r[1]  <= cfg_bus.data;
          CFG_SECOND_GUIDE: cp_r[2]  <= cfg_bus.data;
          CFG_END_POINT:    cp_r[3]  <= cfg_bus.data;
          CFG_SUBDIVISIONS: subdiv_r <= cfg_bus.data[SUBDIV_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_bus.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_bus.valid) begin
            op_r      <= in_bus.operation;
            dist_r    <= in_bus.distance;
            n_r       <= n_cur;
            i_r       <= NW'(1);
            acc_r     <= '0;
            interp_r  <= 1'b0;
            sc_r      <= '0;
            phase_r   <= 1'b0;
            lvl_r     <= 2'd3;
            res_len_r <= '0;
            res_end_r <= 1'b0;
            for (int c = 0; c < 3; c++) begin
              res_pos_r[c] <= '0;
              first_r[c]   <= cps[0][c];
            end
            case (in_bus.operation)
              OP_EVAL: begin
                t_r <= (in_bus.param_t > T_ONE) ? T_ONE : in_bus.param_t;
                for (int k = 0; k < 4; k++) begin
                  for (int c = 0; c < 3; c++) begin
                    q_r[3*k+c] <= cps[k][c];
                  end
                end
                state_r <= S_QSTEP;
              end
              OP_LENGTH, OP_AT_DIST: begin
                state_r <= S_DIVGO;
              end
              default: begin
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_DIVGO: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            t_r     <= div_quo;
            sc_r    <= '0;
            phase_r <= 1'b0;
            lvl_r   <= 2'd3;
            if (interp_r) begin
              for (int c = 0; c < 3; c++) begin
                q_r[c]   <= first_r[c];
                q_r[3+c] <= second_r[c];
              end
            end else begin
              for (int k = 0; k < 4; k++) begin
                for (int c = 0; c < 3; c++) begin
                  q_r[3*k+c] <= cps[k][c];
                end
              end
            end
            state_r <= S_QSTEP;
          end
        end
        S_QSTEP: begin
          if (lerp_now && !phase_r) begin
            prod_r  <= mul_p;
            phase_r <= 1'b1;
          end else begin
            for (int j = 0; j < 11; j++) begin
              q_r[j] <= q_r[j+1];
            end
            q_r[11] <= lerp_now ? lerp_res : q_r[0];
            phase_r <= 1'b0;
            if (sc_r == 4'd11) begin
              sc_r <= '0;
              if (interp_r || lvl_r == 2'd1) begin
                state_r <= S_EVDONE;
              end else begin
                lvl_r <= lvl_r - 2'd1;
              end
            end else begin
              sc_r <= sc_r + 4'd1;
            end
          end
        end
        S_EVDONE: begin
          if (interp_r || op_r == OP_EVAL) begin
            for (int c = 0; c < 3; c++) begin
              res_pos_r[c] <= q_r[c];
            end
            state_r <= S_OUT;
          end else begin
            for (int c = 0; c < 3; c++) begin
              second_r[c] <= q_r[c];
            end
            sq_cnt_r <= '0;
            sum_r    <= '0;
            state_r  <= S_SQ;
          end
        end
        S_SQ: begin
          if (sq_cnt_r != 2'd3) begin
            prod_r <= mul_p;
          end
          if (sq_cnt_r != 2'd0) begin
            sum_r <= sum_r + prod_r[SQ_W-1:0];
          end
          if (sq_cnt_r == 2'd3) begin
            state_r <= S_SQRT;
          end
          sq_cnt_r <= sq_cnt_r + 2'd1;
        end
        S_SQRT: begin
          if (sqrt_done) begin
            seg_r   <= SEG_W'(sqrt_root) << sh;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (hit) begin
            if (seg_r == '0) begin
              for (int c = 0; c < 3; c++) begin
                res_pos_r[c] <= first_r[c];
              end
              state_r <= S_OUT;
            end else begin
              interp_r <= 1'b1;
              state_r  <= S_DIVGO;
            end
          end else begin
            acc_r <= acc_seg;
            for (int c = 0; c < 3; c++) begin
              first_r[c] <= second_r[c];
            end
            if (i_r == n_r) begin
              if (op_r == OP_LENGTH) begin
                res_len_r <= (acc_seg > ACC_W'(LEN_MAX)) ? LEN_MAX : LEN_W'(acc_seg);
              end else begin
                for (int c = 0; c < 3; c++) begin
                  res_pos_r[c] <= cps[3][c];
                end
                res_end_r <= 1'b1;
              end
              state_r <= S_OUT;
            end else begin
              i_r     <= i_r + NW'(1);
              state_r <= S_DIVGO;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_bus.ready) begin
            for (int c = 0; c < 3; c++) begin
              out_pos_r[c] <= res_pos_r[c];
            end
            out_len_r   <= res_len_r;
            out_end_r   <= res_end_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.pos_x        = out_pos_r[0];
  assign out_bus.pos_y        = out_pos_r[1];
  assign out_bus.pos_z        = out_pos_r[2];
  assign out_bus.curve_length = out_len_r;
  assign out_bus.reached_end  = out_end_r;

  // The divider and the root unit report only while the sequencer waits on them.
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside its wait state");

  a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> state_r == S_SQRT)
    else $error("square root finished outside its wait state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> state_r != S_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_chord_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (i_r <= n_r && i_r != '0))
    else $error("chord index out of range");

endmodule

`default_nettype wire

### tb/sv/tb_bezier_arc_length_walker_core.sv
// ============================================================================
// tb_bezier_arc_length_walker_core
// Self-checking bench for the cubic Bezier arc-length walker. A behavioral
// predictor of the curve, chord sum and distance walk computes the expected
// result of every request. Named tests cover reset defaults, coordinate
// extremes, subdivision limits, back-pressure and random curves, with bursty
// requests and a stalling result sink.
// ============================================================================
`timescale 1ns / 100ps

module tb_bezier_arc_length_walker_core;
  import bal_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 40;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef longint vec3_t [3];
  typedef struct {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [LEN_W-1:0]   curve_length;
    logic               reached_end;
  } point_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bal_in_if                in_bus ();
  bal_out_if #(.POS_W(24)) out_bus ();
  bal_cfg_if #(.DATA_W(48)) cfg_bus ();

  bezier_arc_length_walker_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  logic [47:0]         ctrl_pts [4];
  logic [SUBDIV_W-1:0] subdiv_reg;
  point_result_t       pending_results [$];
  int                  mismatches = 0;
  longint              cycles = 0;
  int                  burst_left = 0;
  int                  hold_request = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_bezier_arc_length_walker_core: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint lerp_q16(longint a, longint b, longint t);
    longint p;
    p = (b - a) * t;
    return a + ((p + 32768) >>> 16);
  endfunction

  function automatic vec3_t ctrl_point(int k);
    vec3_t v;
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'($signed(ctrl_pts[k][i*16 +: 16])) * 256;
    end
    return v;
  endfunction

  function automatic vec3_t curve_at(longint t);
    vec3_t p [4];
    for (int k = 0; k < 4; k++) p[k] = ctrl_point(k);
    for (int lvl = 3; lvl > 0; lvl--) begin
      for (int k = 0; k < lvl; k++) begin
        for (int i = 0; i < 3; i++) p[k][i] = lerp_q16(p[k][i], p[k+1][i], t);
      end
    end
    return p[0];
  endfunction

  function automatic longint unsigned root_rounded(longint unsigned n);
    longint unsigned rem, r, bitv;
    rem = n;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= r + bitv) begin
        rem = rem - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    if (r * r + r < n) r = r + 1;
    return r;
  endfunction

  function automatic longint unsigned chord_length(vec3_t a, vec3_t b);
    longint unsigned mag [3];
    longint unsigned m, sum;
    longint d;
    int sh;
    m = 0;
    sum = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      d = b[i] - a[i];
      mag[i] = (d < 0) ? longint'(-d) : d;
      if (mag[i] > m) m = mag[i];
    end
    while ((m >> sh) >= (64'd1 << 31)) sh++;
    for (int i = 0; i < 3; i++) sum += (mag[i] >> sh) * (mag[i] >> sh);
    return root_rounded(sum) << sh;
  endfunction

  function automatic point_result_t predict_request(logic [OP_W-1:0] op,
                                                    logic [T_W-1:0] t_in,
                                                    logic [DIST_W-1:0] dist_in);
    point_result_t res;
    vec3_t pos, first, second;
    longint unsigned n, acc, seg, offset, f, t;
    bit found;
    pos = '{0, 0, 0};
    res.curve_length = '0;
    res.reached_end = 1'b0;
    n = (subdiv_reg == 0) ? 1 : (subdiv_reg > 256) ? 256 : subdiv_reg;
    if (op == OP_EVAL) begin
      t = (t_in > T_ONE) ? T_ONE : t_in;
      pos = curve_at(t);
    end else if (op == OP_LENGTH || op == OP_AT_DIST) begin
      acc = 0;
      found = 0;
      first = curve_at(0);
      for (longint unsigned i = 0; i < n && !found; i++) begin
        second = curve_at(((i + 1) * 65536 + n / 2) / n);
        seg = chord_length(first, second);
        if (op == OP_AT_DIST && acc + seg > dist_in) begin
          offset = dist_in - acc;
          found = 1;
          if (seg == 0) begin
            pos = first;
          end else begin
            f = (offset * 65536 + seg / 2) / seg;
            for (int k = 0; k < 3; k++) pos[k] = lerp_q16(first[k], second[k], f);
          end
        end else begin
          acc += seg;
        end
        first = second;
      end
      if (op == OP_LENGTH) begin
        res.curve_length = (acc > LEN_MAX) ? LEN_MAX : acc[LEN_W-1:0];
      end else if (!found) begin
        pos = ctrl_point(3);
        res.reached_end = 1'b1;
      end
    end
    res.pos_x = pos[0][23:0];
    res.pos_y = pos[1][23:0];
    res.pos_z = pos[2][23:0];
    return res;
  endfunction

  // ------------------------------------------------------------ result sink
  initial begin
    int hold;
    logic [15:0] pattern;
    hold = 0;
    pattern = 16'hFFFF;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (cycles % 400 == 0) begin
        pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      end
      if (hold > 0) begin
        hold--;
        out_bus.ready = 1'b0;
      end else begin
        out_bus.ready = pattern[cycles % 16];
      end
    end
  end

  always @(posedge clk) begin
    point_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
      end else begin
        want = pending_results.pop_front();
        if (out_bus.pos_x !== want.pos_x || out_bus.pos_y !== want.pos_y ||
            out_bus.pos_z !== want.pos_z || out_bus.curve_length !== want.curve_length ||
            out_bus.reached_end !== want.reached_end) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected %0d %0d %0d len %0d end %0d, got %0d %0d %0d len %0d end %0d",
                     want.pos_x, want.pos_y, want.pos_z, want.curve_length,
                     want.reached_end, out_bus.pos_x, out_bus.pos_y, out_bus.pos_z,
                     out_bus.curve_length, out_bus.reached_end);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_request(logic [OP_W-1:0] op, logic [T_W-1:0] t,
                              logic [DIST_W-1:0] req_dist);
    if (burst_left == 0) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_bus.operation = op;
    in_bus.param_t = t;
    in_bus.distance = req_dist;
    in_bus.valid = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    pending_results.push_back(predict_request(op, t, req_dist));
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [47:0] data);
    wait_idle();
    cfg_bus.index = idx;
    cfg_bus.data = data;
    cfg_bus.valid = 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx < CFG_SUBDIVISIONS) ctrl_pts[idx] = data;
    else if (idx == CFG_SUBDIVISIONS) subdiv_reg = data[SUBDIV_W-1:0];
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic load_curve(logic [47:0] p0, logic [47:0] p1, logic [47:0] p2,
                            logic [47:0] p3, logic [47:0] n);
    write_register(CFG_START_POINT, p0);
    write_register(CFG_FIRST_GUIDE, p1);
    write_register(CFG_SECOND_GUIDE, p2);
    write_register(CFG_END_POINT, p3);
    write_register(CFG_SUBDIVISIONS, n);
  endtask

  function automatic logic [47:0] random_point(bit wide);
    logic [47:0] p;
    for (int i = 0; i < 3; i++) begin
      p[i*16 +: 16] = wide ? 16'($urandom) : 16'($urandom_range(0, 400) - 200);
    end
    return p;
  endfunction

  function automatic logic [DIST_W-1:0] pick_distance();
    point_result_t len_res;
    longint unsigned total;
    len_res = predict_request(OP_LENGTH, '0, '0);
    total = len_res.curve_length;
    case ($urandom_range(0, 9))
      0: return DIST_W'($urandom);
      1: return DIST_W'(total);
      2: return DIST_W'(total + $urandom_range(1, 1000));
      3: return (total > 0) ? DIST_W'(total - 1) : '0;
      default: return DIST_W'($urandom_range(0, 32'(total)));
    endcase
  endfunction

  // ------------------------------------------------------------------ tests
  task automatic test_reset_defaults();
    send_request(OP_EVAL, 17'd32768, '0);
    send_request(OP_LENGTH, '0, '0);
    send_request(OP_AT_DIST, '0, '0);
    send_request(OP_UNUSED, 17'h1FFFF, {DIST_W{1'b1}});
  endtask

  task automatic test_coordinate_extremes();
    load_curve(48'h8000_8000_8000, 48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000,
               48'h7FFF_7FFF_7FFF, 48'd256);
    send_request(OP_EVAL, '0, '0);
    send_request(OP_EVAL, T_ONE, '0);
    send_request(OP_EVAL, 17'h1FFFF, '0);
    send_request(OP_EVAL, 17'd1, '0);
    send_request(OP_LENGTH, '0, '0);
    send_request(OP_AT_DIST, '0, 27'd12345678);
    send_request(OP_AT_DIST, '0, {DIST_W{1'b1}});
  endtask

  task automatic test_subdivision_limits();
    load_curve(48'h0000_0000_0000, 48'h0000_0064_0000, 48'h0064_0064_0000,
               48'h0064_0000_0000, 48'd0);
    send_request(OP_LENGTH, '0, '0);
    send_request(OP_AT_DIST, '0, 27'd4000);
    write_register(CFG_SUBDIVISIONS, 48'd300);
    send_request(OP_LENGTH, '0, '0);
    write_register(CFG_SUBDIVISIONS, 48'hFFFF_FFFF_FE03);
    send_request(OP_LENGTH, '0, '0);
    send_request(OP_AT_DIST, '0, pick_distance());
    load_curve(48'h0123_0456_0789, 48'h0123_0456_0789, 48'h0123_0456_0789,
               48'h0123_0456_0789, 48'd5);
    send_request(OP_LENGTH, '0, '0);
    send_request(OP_AT_DIST, '0, '0);
    send_request(OP_EVAL, 17'd40000, '0);
  endtask

  task automatic test_back_pressure();
    load_curve(random_point(1), random_point(1), random_point(1),
               random_point(1), 48'd2);
    wait_idle();
    hold_request = 3000;
    repeat (6) send_request(OP_EVAL, T_W'($urandom_range(0, 70000)), '0);
    wait_idle();
    repeat (4) send_request(OP_AT_DIST, '0, pick_distance());
  endtask

  task automatic test_random_curves();
    int op_pick;
    for (int phase = 0; phase < 6; phase++) begin
      load_curve(random_point(phase % 2 == 0), random_point(phase % 3 != 1),
                 random_point(phase % 2 == 1), random_point(phase != 3),
                 48'($urandom_range(1, 14)));
      for (int i = 0; i < 12; i++) begin
        op_pick = $urandom_range(0, 19);
        if (op_pick < 7) begin
          send_request(OP_EVAL, T_W'($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 65536)),
                       DIST_W'($urandom));
        end else if (op_pick < 11) begin
          send_request(OP_LENGTH, T_W'($urandom), DIST_W'($urandom));
        end else if (op_pick < 19) begin
          send_request(OP_AT_DIST, T_W'($urandom), pick_distance());
        end else begin
          send_request(OP_UNUSED, T_W'($urandom), DIST_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.operation = OP_EVAL;
    in_bus.param_t = '0;
    in_bus.distance = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_START_POINT;
    cfg_bus.data = '0;
    for (int k = 0; k < 4; k++) ctrl_pts[k] = '0;
    subdiv_reg = SUBDIV_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_coordinate_extremes();
    test_subdivision_limits();
    test_back_pressure();
    test_random_curves();

    wait_idle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_bezier_arc_length_walker_core: done, clean");
    end else begin
      $display("tb_bezier_arc_length_walker_core: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/bal_pkg.sv
hw/rtl/bal_if.sv
hw/rtl/bal_div.sv
hw/rtl/bal_isqrt.sv
hw/rtl/bezier_arc_length_walker_core.sv
tb/sv/tb_bezier_arc_length_walker_core.sv
